// ===== rtl/cubic_bezier_tessellator_defines.svh =====
// Assertion macros shared by the tessellator RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef CUBIC_BEZIER_TESSELLATOR_DEFINES_SVH
`define CUBIC_BEZIER_TESSELLATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CBT_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("cbt same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CBT_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("cbt next-cycle check failed");

`endif

// ===== rtl/cbt_pkg.sv =====
// Types and constants for the cubic Bezier tessellator.
// No dependencies.
package cbt_pkg;

    localparam int SEG_W          = 6;
    localparam int OFF_W          = 23;
    localparam int CFG_DATA_W     = 23;
    localparam int CFG_IDX_W      = 1;
    localparam int WT_W           = 18;  // Bernstein weights, n <= 63
    localparam int D3_W           = 18;  // n^3
    localparam int NN_W           = 12;  // n^2, u^2, i^2
    localparam int DIFF_CLAMP_LOG = 25;
    localparam int ROOT_W         = 26;
    localparam int SQ_W           = 52;
    localparam int RCNT_W         = 5;

    localparam logic [SEG_W-1:0] SEG_RESET = 6'd16;
    localparam logic [OFF_W-1:0] OFF_RESET = 23'd25600;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEGMENT_COUNT      = 1'b0,
        CFG_MAX_CONTROL_OFFSET = 1'b1
    } cfg_reg_t;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SETUP  = 8'b0000_0010,
        S_ROOT   = 8'b0000_0100,
        S_OFFSET = 8'b0000_1000,
        S_POINT  = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_DFIX   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    // Multiplier micro-steps: setup steps, then per-point steps.
    typedef enum logic [4:0] {
        ST_SQX = 5'd0,
        ST_SQY = 5'd1,
        ST_NN  = 5'd2,
        ST_D3  = 5'd3,
        ST_UU  = 5'd4,
        ST_W0  = 5'd5,
        ST_II  = 5'd6,
        ST_W3  = 5'd7,
        ST_W1  = 5'd8,
        ST_W2  = 5'd9,
        ST_X0  = 5'd10,
        ST_X1  = 5'd11,
        ST_X2  = 5'd12,
        ST_X3  = 5'd13,
        ST_Y0  = 5'd14,
        ST_Y1  = 5'd15,
        ST_Y2  = 5'd16,
        ST_Y3  = 5'd17
    } step_t;

endpackage

// ===== rtl/cbt_curve_if.sv =====
// Input channel of the tessellator: one curve per transfer.
// No dependencies.
interface cbt_curve_if #(parameter int COORD_WIDTH = 24);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== rtl/cbt_point_if.sv =====
// Output channel of the tessellator: one curve point per transfer.
// No dependencies.
interface cbt_point_if #(parameter int COORD_WIDTH = 24);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic [5:0]                    point_index;
    logic                          last_point;

    modport source (output valid, point_x, point_y, point_index, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_index, last_point, output ready);
endinterface

// ===== rtl/cubic_bezier_tessellator.sv =====
// One curve at a time: curve.ready is high only in idle, so a new curve is taken only after
// the last point of the previous one has gone out, and output stalls hold the block. The shared
// multiplier, the 26-step square root and the bit-serial divider (two passes per point) do
// the work.
// Reset (rst_n, async, active low): idle, segment_count = 16, max_control_offset = 100.0.
// Depends on cbt_pkg, cbt_curve_if, cbt_point_if and cubic_bezier_tessellator_defines.svh.
`include "cubic_bezier_tessellator_defines.svh"

module cubic_bezier_tessellator #(
    parameter int COORD_WIDTH  = 24,
    parameter int MAX_SEGMENTS = 63
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [cbt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cbt_pkg::CFG_DATA_W-1:0]  cfg_data,
    cbt_curve_if.sink                       curve,
    cbt_point_if.source                     point
);

    // Multiplier operand width: coordinates plus control offset, or clamped deltas.
    localparam int MW  = (COORD_WIDTH + 2 > 27) ? COORD_WIDTH + 2 : 27;
    localparam int PW  = 2 * MW;
    // Accumulator: n^3 * |coord| and the sum of squares both fit.
    localparam int AW  = (COORD_WIDTH + 21 > 53) ? COORD_WIDTH + 21 : 53;
    localparam int DW  = AW + 1;           // divider dividend magnitude
    localparam int DCW = $clog2(DW + 1);

    localparam logic [MW-1:0] DIFF_CLAMP = MW'(1) << cbt_pkg::DIFF_CLAMP_LOG;
    localparam logic signed [DW:0] CMAX =
        (DW + 1)'((longint'(1) <<< (COORD_WIDTH - 1)) - 1);
    localparam logic signed [DW:0] CMIN = -CMAX - 1;

    localparam int SW = cbt_pkg::SEG_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    // Control
    cbt_pkg::state_t                state_reg;
    cbt_pkg::step_t                 step_reg;
    logic                           phase_reg;    // 0: multiply, 1: write back
    logic [cbt_pkg::RCNT_W-1:0]     rcnt_reg;
    logic [DCW-1:0]                 dcnt_reg;
    logic                           div_y_reg;
    logic [SW-1:0]                  i_reg;
    logic [SW-1:0]                  seg_reg;
    logic [cbt_pkg::OFF_W-1:0]      max_off_reg;

    // Datapath (curve_points and control_offset live here)
    logic signed [COORD_WIDTH-1:0]  sx_reg, sy_reg, ex_reg, ey_reg;
    logic [SW-1:0]                  n_reg;
    logic [cbt_pkg::NN_W-1:0]       nn_reg, uu_reg, ii_reg;
    logic [cbt_pkg::D3_W-1:0]       d3_reg;
    logic [cbt_pkg::WT_W-1:0]       w0_reg, w1_reg, w2_reg, w3_reg;
    logic [cbt_pkg::OFF_W-1:0]      off_reg;
    logic signed [MW-1:0]           c1x_reg, c2x_reg;
    logic signed [PW-1:0]           prod_reg;
    logic signed [AW-1:0]           acc_x_reg, acc_y_reg;
    logic [cbt_pkg::SQ_W-1:0]       rx_reg, r_reg;
    logic [DW-1:0]                  dq_reg;
    logic [cbt_pkg::D3_W-1:0]       drem_reg;
    logic                           neg_reg;
    logic signed [COORD_WIDTH-1:0]  px_reg, py_reg;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    function automatic logic [MW-1:0] abs_clamp(input logic signed [MW-1:0] v);
        logic [MW-1:0] a;
        a = v[MW-1] ? MW'(-v) : MW'(v);
        return (a > DIFF_CLAMP) ? DIFF_CLAMP : a;
    endfunction

    logic [MW-1:0]          adx, ady;
    logic [SW-1:0]          u_val;
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [PW-1:0]   prod_full;
    logic signed [AW-1:0]   prod_acc;
    logic [cbt_pkg::WT_W-1:0] prod_x3;
    logic                   step_last;

    assign adx      = abs_clamp(MW'(ex_reg) - MW'(sx_reg));
    assign ady      = abs_clamp(MW'(ey_reg) - MW'(sy_reg));
    assign u_val    = n_reg - i_reg;
    assign prod_acc = signed'(prod_reg[AW-1:0]);
    // Weights w1, w2 carry the factor 3: t + 2t
    assign prod_x3  = prod_reg[cbt_pkg::WT_W-1:0] + {prod_reg[cbt_pkg::WT_W-2:0], 1'b0};
    assign step_last = (step_reg == cbt_pkg::ST_D3) || (step_reg == cbt_pkg::ST_Y3);

    // Operand select for the one shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (step_reg)
            cbt_pkg::ST_SQX: begin mul_a = signed'(adx); mul_b = signed'(adx); end
            cbt_pkg::ST_SQY: begin mul_a = signed'(ady); mul_b = signed'(ady); end
            cbt_pkg::ST_NN:
            begin
                mul_a = signed'(MW'(n_reg));  mul_b = signed'(MW'(n_reg));
            end
            cbt_pkg::ST_D3:
            begin
                mul_a = signed'(MW'(nn_reg)); mul_b = signed'(MW'(n_reg));
            end
            cbt_pkg::ST_UU:
            begin
                mul_a = signed'(MW'(u_val));  mul_b = signed'(MW'(u_val));
            end
            cbt_pkg::ST_W0:
            begin
                mul_a = signed'(MW'(uu_reg)); mul_b = signed'(MW'(u_val));
            end
            cbt_pkg::ST_II:
            begin
                mul_a = signed'(MW'(i_reg));  mul_b = signed'(MW'(i_reg));
            end
            cbt_pkg::ST_W3:
            begin
                mul_a = signed'(MW'(ii_reg)); mul_b = signed'(MW'(i_reg));
            end
            cbt_pkg::ST_W1:
            begin
                mul_a = signed'(MW'(uu_reg)); mul_b = signed'(MW'(i_reg));
            end
            cbt_pkg::ST_W2:
            begin
                mul_a = signed'(MW'(u_val));  mul_b = signed'(MW'(ii_reg));
            end
            cbt_pkg::ST_X0: begin mul_a = signed'(MW'(w0_reg)); mul_b = MW'(sx_reg); end
            cbt_pkg::ST_X1: begin mul_a = signed'(MW'(w1_reg)); mul_b = c1x_reg; end
            cbt_pkg::ST_X2: begin mul_a = signed'(MW'(w2_reg)); mul_b = c2x_reg; end
            cbt_pkg::ST_X3: begin mul_a = signed'(MW'(w3_reg)); mul_b = MW'(ex_reg); end
            cbt_pkg::ST_Y0: begin mul_a = signed'(MW'(w0_reg)); mul_b = MW'(sy_reg); end
            cbt_pkg::ST_Y1: begin mul_a = signed'(MW'(w1_reg)); mul_b = MW'(sy_reg); end
            cbt_pkg::ST_Y2: begin mul_a = signed'(MW'(w2_reg)); mul_b = MW'(ey_reg); end
            cbt_pkg::ST_Y3: begin mul_a = signed'(MW'(w3_reg)); mul_b = MW'(ey_reg); end
            default:        begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // Integer square root, one result bit per cycle
    logic [5:0]               root_sh;
    logic [cbt_pkg::SQ_W-1:0] root_bit, root_try;
    assign root_sh  = {5'(cbt_pkg::ROOT_W - 1) - rcnt_reg, 1'b0};
    assign root_bit = cbt_pkg::SQ_W'(1) << root_sh;
    assign root_try = r_reg + root_bit;

    // Control offset: min(floor(d/2), cap)
    logic [cbt_pkg::ROOT_W-2:0] half;
    logic [cbt_pkg::OFF_W-1:0]  off_val;
    assign half    = r_reg[cbt_pkg::ROOT_W-1:1];
    assign off_val = (half < (cbt_pkg::ROOT_W - 1)'(max_off_reg)) ?
                     half[cbt_pkg::OFF_W-1:0] : max_off_reg;

    // Divider load: v = num + floor(n^3/2), split into sign and magnitude
    logic signed [AW-1:0] div_src;
    logic signed [AW:0]   div_v;
    logic [DW-1:0]        div_mag;
    assign div_src = (state_reg == cbt_pkg::S_DFIX) ? acc_y_reg : acc_x_reg;
    assign div_v   = (AW + 1)'(div_src) + signed'((AW + 1)'(d3_reg >> 1));
    assign div_mag = div_v[AW] ? DW'(-div_v) : DW'(div_v);

    // Restoring division step
    logic [cbt_pkg::D3_W:0]   div_sh;
    logic                     div_bit;
    logic [cbt_pkg::D3_W-1:0] drem_next;
    assign div_sh    = {drem_reg, dq_reg[DW-1]};
    assign div_bit   = div_sh >= {1'b0, d3_reg};
    assign drem_next = div_bit ? cbt_pkg::D3_W'(div_sh - {1'b0, d3_reg})
                               : div_sh[cbt_pkg::D3_W-1:0];

    // Floor correction for negative dividends, then saturation
    logic signed [DW:0]            q_ext, q_floor;
    logic signed [COORD_WIDTH-1:0] q_sat;
    assign q_ext   = signed'({1'b0, dq_reg});
    assign q_floor = neg_reg ? -(q_ext + (DW + 1)'(drem_reg != '0)) : q_ext;
    always_comb
    begin
        priority if (q_floor > CMAX)
            q_sat = COORD_WIDTH'(CMAX);
        else if (q_floor < CMIN)
            q_sat = COORD_WIDTH'(CMIN);
        else
            q_sat = COORD_WIDTH'(q_floor);
    end

    logic curve_xfer, point_xfer;
    assign curve_xfer = curve.valid && curve.ready;
    assign point_xfer = point.valid && point.ready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cbt_pkg::S_IDLE;
            step_reg    <= cbt_pkg::ST_SQX;
            phase_reg   <= 1'b0;
            rcnt_reg    <= '0;
            dcnt_reg    <= '0;
            div_y_reg   <= 1'b0;
            i_reg       <= '0;
            seg_reg     <= cbt_pkg::SEG_RESET;
            max_off_reg <= cbt_pkg::OFF_RESET;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cbt_pkg::cfg_reg_t'(cfg_index))
                    cbt_pkg::CFG_SEGMENT_COUNT:      seg_reg     <= cfg_data[SW-1:0];
                    cbt_pkg::CFG_MAX_CONTROL_OFFSET: max_off_reg <= cfg_data;
                    default:                         seg_reg     <= seg_reg;
                endcase
            end

            unique case (state_reg)
                cbt_pkg::S_IDLE:
                begin
                    if (curve_xfer)
                    begin
                        state_reg <= cbt_pkg::S_SETUP;
                        step_reg  <= cbt_pkg::ST_SQX;
                        phase_reg <= 1'b0;
                    end
                end
                cbt_pkg::S_SETUP, cbt_pkg::S_POINT:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        if (step_reg == cbt_pkg::ST_D3)
                        begin
                            state_reg <= cbt_pkg::S_ROOT;
                            rcnt_reg  <= '0;
                        end
                        else if (step_reg == cbt_pkg::ST_Y3)
                        begin
                            state_reg <= cbt_pkg::S_DIV;
                            dcnt_reg  <= '0;
                            div_y_reg <= 1'b0;
                        end
                        else
                            step_reg <= cbt_pkg::step_t'(step_reg + 5'd1);
                    end
                end
                cbt_pkg::S_ROOT:
                begin
                    rcnt_reg <= rcnt_reg + 1'b1;
                    if (rcnt_reg == cbt_pkg::RCNT_W'(cbt_pkg::ROOT_W - 1))
                        state_reg <= cbt_pkg::S_OFFSET;
                end
                cbt_pkg::S_OFFSET:
                begin
                    state_reg <= cbt_pkg::S_POINT;
                    step_reg  <= cbt_pkg::ST_UU;
                    phase_reg <= 1'b0;
                    i_reg     <= '0;
                end
                cbt_pkg::S_DIV:
                begin
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == DCW'(DW - 1))
                        state_reg <= cbt_pkg::S_DFIX;
                end
                cbt_pkg::S_DFIX:
                begin
                    if (!div_y_reg)
                    begin
                        div_y_reg <= 1'b1;
                        dcnt_reg  <= '0;
                        state_reg <= cbt_pkg::S_DIV;
                    end
                    else
                        state_reg <= cbt_pkg::S_OUT;
                end
                cbt_pkg::S_OUT:
                begin
                    if (point.ready)
                    begin
                        if (i_reg == n_reg)
                            state_reg <= cbt_pkg::S_IDLE;
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= cbt_pkg::S_POINT;
                            step_reg  <= cbt_pkg::ST_UU;
                            phase_reg <= 1'b0;
                        end
                    end
                end
                default: state_reg <= cbt_pkg::S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            cbt_pkg::S_IDLE:
            begin
                if (curve_xfer)
                begin
                    sx_reg <= curve.start_x;
                    sy_reg <= curve.start_y;
                    ex_reg <= curve.end_x;
                    ey_reg <= curve.end_y;
                    // zero segments act as one; large counts saturate
                    if (seg_reg == '0)
                        n_reg <= SW'(1);
                    else if (seg_reg > SW'(MAX_SEGMENTS))
                        n_reg <= SW'(MAX_SEGMENTS);
                    else
                        n_reg <= seg_reg;
                end
            end
            cbt_pkg::S_SETUP, cbt_pkg::S_POINT:
            begin
                if (!phase_reg)
                    prod_reg <= prod_full;
                else
                begin
                    unique case (step_reg)
                        cbt_pkg::ST_SQX: acc_x_reg <= prod_acc;
                        cbt_pkg::ST_SQY: acc_x_reg <= acc_x_reg + prod_acc;
                        cbt_pkg::ST_NN:  nn_reg    <= prod_reg[cbt_pkg::NN_W-1:0];
                        cbt_pkg::ST_D3:
                        begin
                            d3_reg <= prod_reg[cbt_pkg::D3_W-1:0];
                            rx_reg <= acc_x_reg[cbt_pkg::SQ_W-1:0];
                            r_reg  <= '0;
                        end
                        cbt_pkg::ST_UU:  uu_reg    <= prod_reg[cbt_pkg::NN_W-1:0];
                        cbt_pkg::ST_W0:  w0_reg    <= prod_reg[cbt_pkg::WT_W-1:0];
                        cbt_pkg::ST_II:  ii_reg    <= prod_reg[cbt_pkg::NN_W-1:0];
                        cbt_pkg::ST_W3:  w3_reg    <= prod_reg[cbt_pkg::WT_W-1:0];
                        cbt_pkg::ST_W1:  w1_reg    <= prod_x3;
                        cbt_pkg::ST_W2:  w2_reg    <= prod_x3;
                        cbt_pkg::ST_X0:  acc_x_reg <= prod_acc;
                        cbt_pkg::ST_X1,
                        cbt_pkg::ST_X2,
                        cbt_pkg::ST_X3:  acc_x_reg <= acc_x_reg + prod_acc;
                        cbt_pkg::ST_Y0:  acc_y_reg <= prod_acc;
                        cbt_pkg::ST_Y1,
                        cbt_pkg::ST_Y2:  acc_y_reg <= acc_y_reg + prod_acc;
                        cbt_pkg::ST_Y3:
                        begin
                            acc_y_reg <= acc_y_reg + prod_acc;
                            // x numerator is final: load the divider
                            dq_reg    <= div_mag;
                            neg_reg   <= div_v[AW];
                            drem_reg  <= '0;
                        end
                        default: acc_y_reg <= acc_y_reg;
                    endcase
                end
            end
            cbt_pkg::S_ROOT:
            begin
                if (rx_reg >= root_try)
                begin
                    rx_reg <= rx_reg - root_try;
                    r_reg  <= (r_reg >> 1) + root_bit;
                end
                else
                    r_reg <= r_reg >> 1;
            end
            cbt_pkg::S_OFFSET:
            begin
                off_reg <= off_val;
                c1x_reg <= MW'(sx_reg) + signed'(MW'(off_val));
                c2x_reg <= MW'(ex_reg) - signed'(MW'(off_val));
            end
            cbt_pkg::S_DIV:
            begin
                drem_reg <= drem_next;
                dq_reg   <= {dq_reg[DW-2:0], div_bit};
            end
            cbt_pkg::S_DFIX:
            begin
                if (!div_y_reg)
                begin
                    px_reg   <= q_sat;
                    dq_reg   <= div_mag;
                    neg_reg  <= div_v[AW];
                    drem_reg <= '0;
                end
                else
                    py_reg <= q_sat;
            end
            cbt_pkg::S_OUT:
            begin
                px_reg <= px_reg;
            end
            default:
            begin
                px_reg <= px_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign curve.ready       = (state_reg == cbt_pkg::S_IDLE);
    assign point.valid       = (state_reg == cbt_pkg::S_OUT);
    assign point.point_x     = px_reg;
    assign point.point_y     = py_reg;
    assign point.point_index = i_reg;
    assign point.last_point  = (i_reg == n_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CBT_ASSERT_IMP(a_ready_not_with_point, curve.ready, !point.valid)
    `CBT_ASSERT_IMP(a_n_in_range, !curve.ready, n_reg != '0 && n_reg <= SW'(MAX_SEGMENTS))
    `CBT_ASSERT_NXT(a_busy_after_accept, curve_xfer, !curve.ready)
    `CBT_ASSERT_NXT(a_idle_after_last, point_xfer && point.last_point, curve.ready)
    `CBT_ASSERT_IMP(a_off_capped, state_reg == cbt_pkg::S_POINT, off_reg <= max_off_reg)
    `CBT_ASSERT_IMP(a_step_in_order, phase_reg && step_last, state_reg != cbt_pkg::S_IDLE)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for cubic_bezier_tessellator: curves in, Bezier points out.
// Depends on cbt_pkg, cbt_curve_if, cbt_point_if and the cubic_bezier_tessellator RTL.
module testbench;

    localparam int CW = 24;
    localparam longint COORD_HI = 64'sd8388607;
    localparam longint COORD_LO = -64'sd8388608;
    localparam longint DIFF_CAP = 64'sd1 << cbt_pkg::DIFF_CLAMP_LOG;

    typedef struct {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
    } curve_t;

    typedef struct {
        logic signed [CW-1:0]      x;
        logic signed [CW-1:0]      y;
        logic [cbt_pkg::SEG_W-1:0] idx;
        logic                      last;
    } point_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                           cfg_write_en;
    logic [cbt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cbt_pkg::CFG_DATA_W-1:0] cfg_data;

    cbt_curve_if #(.COORD_WIDTH(CW)) curve ();
    cbt_point_if #(.COORD_WIDTH(CW)) point ();

    cubic_bezier_tessellator #(.COORD_WIDTH(CW), .MAX_SEGMENTS(63)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .curve        (curve),
        .point        (point)
    );

    always #10 clk = ~clk;

    // Shadow copy of the configuration registers
    logic [cbt_pkg::SEG_W-1:0] seg_shadow;
    logic [cbt_pkg::OFF_W-1:0] off_shadow;

    curve_t pending_curves[$];
    point_t expected_points[$];
    int     error_count;
    int     curves_accepted;
    logic   hold_off;      // long receiver stall
    logic   steady;        // phase with no idling on either side
    int     send_gap;
    int     recv_gap;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint abs_capped(input longint a);
        if (a < 0)
            a = -a;
        return (a > DIFF_CAP) ? DIFF_CAP : a;
    endfunction

    // Nearest, ties toward plus infinity
    function automatic longint div_nearest(input longint num, input longint d);
        longint v;
        v = num + d / 2;
        if (v >= 0)
            return v / d;
        return -((-v + d - 1) / d);
    endfunction

    function automatic logic signed [CW-1:0] clip_coord(input longint v);
        if (v > COORD_HI)
            v = COORD_HI;
        if (v < COORD_LO)
            v = COORD_LO;
        return v[CW-1:0];
    endfunction

    // Expected tessellation of one curve under the current shadow configuration
    task automatic tessellate(input curve_t c);
        longint sx, sy, ex, ey, adx, ady, half, offs, c1x, c2x, n, d3, u;
        longint w0, w1, w2, w3;
        point_t p;
        sx = c.sx;
        sy = c.sy;
        ex = c.ex;
        ey = c.ey;
        adx = abs_capped(ex - sx);
        ady = abs_capped(ey - sy);
        half = longint'(floor_sqrt(adx * adx + ady * ady) >> 1);
        offs = (half < longint'(off_shadow)) ? half : longint'(off_shadow);
        c1x = sx + offs;
        c2x = ex - offs;
        n = (seg_shadow == 0) ? 1 : longint'(seg_shadow);
        d3 = n * n * n;
        for (longint i = 0; i <= n; i++)
        begin
            u = n - i;
            w0 = u * u * u;
            w1 = 3 * u * u * i;
            w2 = 3 * u * i * i;
            w3 = i * i * i;
            p.x = clip_coord(div_nearest(w0 * sx + w1 * c1x + w2 * c2x + w3 * ex, d3));
            p.y = clip_coord(div_nearest(w0 * sy + w1 * sy + w2 * ey + w3 * ey, d3));
            p.idx = i[cbt_pkg::SEG_W-1:0];
            p.last = (i == n);
            expected_points.insert(expected_points.size(), p);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Input driver: next queued curve once the slot is free and any random gap has passed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve.valid   <= 1'b0;
            curve.start_x <= '0;
            curve.start_y <= '0;
            curve.end_x   <= '0;
            curve.end_y   <= '0;
            send_gap      <= 0;
        end
        else if (!curve.valid || curve.ready)
        begin
            if (send_gap > 0)
            begin
                curve.valid <= 1'b0;
                send_gap    <= send_gap - 1;
            end
            else if (pending_curves.size() > 0)
            begin
                curve_t c;
                c = pending_curves.pop_front();
                curve.start_x <= c.sx;
                curve.start_y <= c.sy;
                curve.end_x   <= c.ex;
                curve.end_y   <= c.ey;
                curve.valid   <= 1'b1;
                send_gap      <= steady ? 0 : pick_gap();
            end
            else
                curve.valid <= 1'b0;
        end
    end

    // Output back-pressure: random stalls plus the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point.ready <= 1'b0;
            recv_gap    <= 0;
        end
        else if (hold_off)
            point.ready <= 1'b0;
        else if (recv_gap > 0)
        begin
            point.ready <= 1'b0;
            recv_gap    <= recv_gap - 1;
        end
        else
        begin
            point.ready <= 1'b1;
            if (!steady && $urandom_range(0, 9) == 0)
                recv_gap <= pick_gap();
        end
    end

    // Monitor: check each point transfer, predict on each curve transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (point.valid && point.ready)
            begin
                if (expected_points.size() == 0)
                    report_mismatch($sformatf("unexpected point idx=%0d", point.point_index));
                else
                begin
                    point_t e;
                    e = expected_points.pop_front();
                    if (point.point_x !== e.x)
                        report_mismatch($sformatf("idx %0d point_x %0d, want %0d",
                            e.idx, point.point_x, e.x));
                    if (point.point_y !== e.y)
                        report_mismatch($sformatf("idx %0d point_y %0d, want %0d",
                            e.idx, point.point_y, e.y));
                    if (point.point_index !== e.idx)
                        report_mismatch($sformatf("point_index %0d, want %0d",
                            point.point_index, e.idx));
                    if (point.last_point !== e.last)
                        report_mismatch($sformatf("idx %0d last_point %0b, want %0b",
                            e.idx, point.last_point, e.last));
                end
            end
            if (curve.valid && curve.ready)
            begin
                curve_t c;
                c.sx = curve.start_x;
                c.sy = curve.start_y;
                c.ex = curve.end_x;
                c.ey = curve.end_y;
                tessellate(c);
                curves_accepted++;
            end
        end
    end

    // Long receiver hold-off once traffic is flowing; the block fills and stalls its input
    initial
    begin
        hold_off = 1'b0;
        while (curves_accepted < 60)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic add_curve(input longint sx, input longint sy, input longint ex,
                             input longint ey);
        curve_t c;
        c.sx = sx[CW-1:0];
        c.sy = sy[CW-1:0];
        c.ex = ex[CW-1:0];
        c.ey = ey[CW-1:0];
        pending_curves.insert(pending_curves.size(), c);
    endtask

    task automatic add_directed();
        add_curve(0, 0, 0, 0);                       // coincident points
        add_curve(1234, -5678, 1234, -5678);         // coincident, off origin
        add_curve(COORD_HI, COORD_HI, COORD_HI, COORD_HI);
        add_curve(COORD_LO, COORD_LO, COORD_HI, COORD_HI);   // very distant
        add_curve(COORD_HI, COORD_HI, COORD_LO, COORD_LO);
        add_curve(COORD_LO, COORD_HI, COORD_HI, COORD_LO);
        add_curve(0, COORD_LO, 0, COORD_HI);         // vertical span
        add_curve(0, 0, 2560, 0);                    // short horizontal
        add_curve(-25600, 100, 25600, -100);
        add_curve(100, 0, 100 + 51201, 0);           // half the distance just reaches the default cap
        add_curve(1, 1, -1, -1);
        add_curve(COORD_HI, 0, COORD_HI - 300, 7);   // control x pushed past the top
        add_curve(COORD_LO, -3, COORD_LO + 999, 0);
    endtask

    task automatic add_random(input int count);
        longint sx, sy, ex, ey;
        int r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            sx = longint'($signed(24'($urandom)));
            sy = longint'($signed(24'($urandom)));
            if (r < 40)
            begin
                ex = longint'($signed(24'($urandom)));
                ey = longint'($signed(24'($urandom)));
            end
            else if (r < 80)
            begin
                ex = sx + $urandom_range(0, 120000) - 60000;
                ey = sy + $urandom_range(0, 120000) - 60000;
            end
            else
            begin
                sx = $urandom_range(0, 1) ? COORD_HI - $urandom_range(0, 500)
                                          : COORD_LO + $urandom_range(0, 500);
                ex = $urandom_range(0, 1) ? COORD_HI - $urandom_range(0, 500)
                                          : COORD_LO + $urandom_range(0, 500);
                ey = $urandom_range(0, 1) ? sy : longint'($signed(24'($urandom)));
            end
            add_curve(sx, sy, ex, ey);
        end
    endtask

    task automatic write_reg(input cbt_pkg::cfg_reg_t idx, input int unsigned value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value[cbt_pkg::CFG_DATA_W-1:0];
        if (idx == cbt_pkg::CFG_SEGMENT_COUNT)
            seg_shadow = value[cbt_pkg::SEG_W-1:0];
        else
            off_shadow = value[cbt_pkg::OFF_W-1:0];
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Wait until every queued curve has gone in and every point has come out
    task automatic drain();
        while (pending_curves.size() > 0 || curve.valid || expected_points.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned seg, input int unsigned offs,
                             input int directed, input int randoms);
        write_reg(cbt_pkg::CFG_SEGMENT_COUNT, seg);
        write_reg(cbt_pkg::CFG_MAX_CONTROL_OFFSET, offs);
        if (directed)
            add_directed();
        add_random(randoms);
        drain();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = cbt_pkg::CFG_SEGMENT_COUNT;
        cfg_data     = '0;
        seg_shadow   = cbt_pkg::SEG_RESET;
        off_shadow   = cbt_pkg::OFF_RESET;
        error_count  = 0;
        curves_accepted = 0;
        steady       = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration first, with directed curves
        add_directed();
        drain();

        run_phase(0, 8388607, 1, 40);     // zero segment count, widest cap
        run_phase(63, 0, 1, 2);           // most segments, no control offset
        steady = 1'b1;
        run_phase(1, 25600, 0, 40);
        steady = 1'b0;
        for (int ph = 0; ph < 8; ph++)
        begin
            int unsigned offs;
            offs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8388607)
                                               : $urandom_range(0, 60000);
            run_phase($urandom_range(1, 6), offs, 0, 48);
        end
        run_phase(63, 8388607, 0, 4);

        repeat (200) @(posedge clk);
        if (expected_points.size() != 0)
            report_mismatch($sformatf("%0d points never arrived", expected_points.size()));
        if (error_count == 0)
            $display("** cubic_bezier_tessellator: PASSED **");
        else
            $display("** cubic_bezier_tessellator: FAILED **");
        $finish;
    end

    initial
    begin
        #(20 * 40000000);
        $display("** cubic_bezier_tessellator: FAILED **");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/cbt_pkg.sv
rtl/cbt_curve_if.sv
rtl/cbt_point_if.sv
rtl/cubic_bezier_tessellator.sv
tb/testbench.sv
